// ===== hw/rtl/bst_pkg.sv =====
`default_nettype none

package bst_pkg;

	// set size and count widths
	localparam int CAPACITY  = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 5;
	localparam int VAL_W     = 32;

	// command codes
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// request payload
	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// response payload
	typedef struct packed {
		logic                 was_present;
		logic [OUT_CNT_W-1:0] entry_count;
		logic                 add_dropped;
	} rsp_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic add_en;
		logic rem_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bst_cell.sv =====
`default_nettype none

module bst_cell import bst_pkg::*; (
	input  wire                     clk,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire cell_ctrl_t         ctrl,
	input  wire logic               live,
	input  wire logic               tail,
	input  wire logic signed [VAL_W-1:0] next_data,
	input  wire logic               chain_in,
	output logic signed [VAL_W-1:0] data_q,
	output logic                    chain_out
);

	logic hit;

	// compare against the held entry, fold into the match chain
	assign hit       = live && (data_q == value);
	assign chain_out = chain_in || hit;

	// shift down from the upper neighbor on remove, load at the tail on add
	always_ff @(posedge clk) begin
		if (ctrl.rem_en && chain_out) begin
			data_q <= next_data;
		end else if (ctrl.add_en && tail) begin
			data_q <= value;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_set_table_unit.sv =====
// handshake: an accepted request is held in req_q, and req_stall stays high until
//   it commits; commit waits while an earlier response is stalled, then makes the
//   single compare and shift pass across the row of entry cells and fills rsp_q
// reset: count and handshake state clear at once; entry contents are not
//   cleared and are only read below the count
`default_nettype none

module bounded_set_table_unit import bst_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire logic  req_valid,
	output logic       req_stall,
	input  wire req_t  req,
	output logic       rsp_valid,
	input  wire logic  rsp_stall,
	output rsp_t       rsp
);

	req_t                    req_q;
	logic                    busy_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;
	logic [CNT_W-1:0]        count_q;
	logic                    in_acc;
	logic                    commit;
	logic                    present;
	logic                    room;
	logic                    is_add;
	logic                    is_rem;
	cell_ctrl_t              ctrl;
	logic [CNT_W-1:0]        count_nxt;
	logic signed [VAL_W-1:0] cell_data [CAPACITY];
	logic                    chain     [CAPACITY+1];

	// handshake
	assign req_stall = busy_q;
	assign in_acc    = req_valid && !busy_q;
	assign commit    = busy_q && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// command decode, unused code acts as a query
	assign is_add  = (req_q.cmd == CMD_ADD);
	assign is_rem  = (req_q.cmd == CMD_REMOVE);
	assign present = chain[CAPACITY];
	assign room    = (count_q < CNT_W'(CAPACITY));

	assign ctrl.add_en = commit && is_add && !present && room;
	assign ctrl.rem_en = commit && is_rem;

	// row of entry cells
	assign chain[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] nxt;
		if (i == CAPACITY - 1) begin : g_last
			assign nxt = cell_data[i];
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		bst_cell u_cell (
			.clk       (clk),
			.value     (req_q.value),
			.ctrl      (ctrl),
			.live      (CNT_W'(i) < count_q),
			.tail      (CNT_W'(i) == count_q),
			.next_data (nxt),
			.chain_in  (chain[i]),
			.data_q    (cell_data[i]),
			.chain_out (chain[i+1])
		);
	end

	// next count
	always_comb begin
		count_nxt = count_q;
		if (ctrl.add_en) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.rem_en && present) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= req;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.was_present <= present;
			rsp_q.entry_count <= OUT_CNT_W'(count_nxt);
			rsp_q.add_dropped <= is_add && !present && !room;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			count_q <= count_nxt;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q)
		else $error("accepted request not held");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.rem_en && present) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not shrink count");

	a_drop_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.add_dropped) |-> !rsp_q.was_present)
		else $error("drop flagged for present value");

endmodule

`default_nettype wire
